// ===== hdl/card_deck_shuffler_defines.svh =====
// Assertion macros shared by the card deck shuffler modules.
`ifndef CARD_DECK_SHUFFLER_DEFINES_SVH
`define CARD_DECK_SHUFFLER_DEFINES_SVH
`ifndef SYNTH
`define CDS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("card deck shuffler assertion failed");
`define CDS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("card deck shuffler assertion failed");
`else
`define CDS_ASSERT(lbl, ck, rs, prop)
`define CDS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== hdl/cds_pkg.sv =====
// Package with the types, constants and card decode function of the card deck shuffler.
`timescale 1ns / 1ps
package cds_pkg;

  localparam int RND_W     = 27;
  localparam int FUNC_W    = 2;
  localparam int VALUE_W   = 4;
  localparam int SUIT_W    = 3;
  localparam int LEFT_W    = 6;
  localparam int PASS_W    = 4;
  localparam int CARD_W    = 6;
  localparam int STEP_W    = 5;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [CARD_W-1:0]  RANKS       = 6'd13;
  localparam logic [VALUE_W-1:0] RANK_BASE   = 4'd2;
  localparam logic [SUIT_W-1:0]  SUIT_BASE   = 3'd1;
  localparam logic [PASS_W-1:0]  PASSES_RST  = 4'd10;
  localparam logic               REG_PASSES  = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ORDER   = 2'd0,
    FUNC_SHUFFLE = 2'd1,
    FUNC_DEAL    = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_DEAL_READ,
    ST_DEAL,
    ST_FINISH
  } state_t;

  function automatic logic [VALUE_W-1:0] rank_of(input logic [CARD_W-1:0] card);
    logic [CARD_W-1:0] r;
    r = card;
    for (int i = 0; i < 4; i++) begin
      if (r >= RANKS) begin
        r = r - RANKS;
      end
    end
    return VALUE_W'(r) + RANK_BASE;
  endfunction

endpackage

// ===== hdl/card_deck_shuffler.sv =====
// Top level of the card deck shuffler: deck memory, control sequencer and register port.
//
//   channel   handshake                       payload
//   command   start / busy                    func, random_word
//   result    done (one-cycle strobe)         card_valid, card_value, card_suit,
//                                             shuffle_done, cards_left
//   config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A shuffle step that swaps runs the bit-serial modulo, then a read of both cards, two
// writes through the single memory write port, and the result beat. A deal of a card
// passes through the registered memory read; every other command, including a shuffle
// step without a swap and a deal from an empty deck, goes straight to the finish state.
// After reset the deck is ordered at once, through per-entry valid bits.
// The result beat cannot be stalled; a new command may start in the cycle of done.
`timescale 1ns / 1ps
`include "card_deck_shuffler_defines.svh"
module card_deck_shuffler #(
  parameter int DECK_SIZE = 52
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cds_pkg::FUNC_W-1:0]  func,
  input  logic [cds_pkg::RND_W-1:0]   random_word,
  output logic                        done,
  output logic                        card_valid,
  output logic [cds_pkg::VALUE_W-1:0] card_value,
  output logic [cds_pkg::SUIT_W-1:0]  card_suit,
  output logic                        shuffle_done,
  output logic [cds_pkg::LEFT_W-1:0]  cards_left,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cds_pkg::PADDR_W-1:0] paddr,
  input  logic [cds_pkg::APB_W-1:0]   pwdata,
  output logic [cds_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);

  localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int CW = $clog2(DECK_SIZE + 1);
  localparam logic [CW-1:0] DECK_N = CW'(DECK_SIZE);

  cds_pkg::state_t state, state_next;

  logic [cds_pkg::PASS_W-1:0] shuffle_passes;
  logic [cds_pkg::PASS_W-1:0] pass_count;
  logic [CW-1:0]              swap_pos;
  logic [CW-1:0]              dealt;
  logic [CW-1:0]              left;
  logic [CW-1:0]              top_pos;
  logic [CW-1:0]              swap_inc;
  logic [AW-1:0]              addr_a;
  logic [AW-1:0]              addr_b;
  logic [AW-1:0]              rd_a;
  logic [AW-1:0]              rd_b;
  logic                       vld_a;
  logic                       vld_b;
  logic [AW-1:0]              card_a;
  logic [AW-1:0]              card_b;
  logic [cds_pkg::CARD_W-1:0] card_wide;
  logic [DECK_SIZE-1:0]       filled;
  logic [AW-1:0]              mem [DECK_SIZE];
  logic                       accept;
  logic                       active;
  logic                       cfg_write;
  logic                       mod_load;
  logic                       mod_done;
  logic [CW-1:0]              mod_rem;
  cds_pkg::func_t             cmd;

  assign cmd       = cds_pkg::func_t'(func);
  assign busy      = (state != cds_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign left      = DECK_N - dealt;
  assign top_pos   = dealt + swap_pos;
  assign swap_inc  = swap_pos + CW'(1);
  assign active    = (pass_count < shuffle_passes);
  assign card_a    = vld_a ? rd_a : addr_a;
  assign card_b    = vld_b ? rd_b : addr_b;
  assign card_wide = cds_pkg::CARD_W'(card_a);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == cds_pkg::REG_PASSES) ?
                     cds_pkg::APB_W'(shuffle_passes) : '0;

  cds_serial_mod #(
    .DIV_W(CW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .load      (mod_load),
    .dividend  (random_word),
    .divisor   (left - swap_pos),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mod_load   = 1'b0;
    unique case (state)
      cds_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            cds_pkg::FUNC_SHUFFLE: begin
              if (active && (swap_pos < left)) begin
                mod_load   = 1'b1;
                state_next = cds_pkg::ST_DIVIDE;
              end else begin
                state_next = cds_pkg::ST_FINISH;
              end
            end
            cds_pkg::FUNC_DEAL: begin
              if (dealt < DECK_N) begin
                state_next = cds_pkg::ST_DEAL_READ;
              end else begin
                state_next = cds_pkg::ST_FINISH;
              end
            end
            default: state_next = cds_pkg::ST_FINISH;
          endcase
        end
      end
      cds_pkg::ST_DIVIDE: begin
        if (mod_done) begin
          state_next = cds_pkg::ST_READ;
        end
      end
      cds_pkg::ST_READ:      state_next = cds_pkg::ST_WRITE_A;
      cds_pkg::ST_WRITE_A:   state_next = cds_pkg::ST_WRITE_B;
      cds_pkg::ST_WRITE_B:   state_next = cds_pkg::ST_FINISH;
      cds_pkg::ST_DEAL_READ: state_next = cds_pkg::ST_DEAL;
      cds_pkg::ST_DEAL:      state_next = cds_pkg::ST_FINISH;
      cds_pkg::ST_FINISH:    state_next = cds_pkg::ST_IDLE;
      default:               state_next = cds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shuffle_passes <= cds_pkg::PASSES_RST;
      pass_count     <= '0;
      swap_pos       <= '0;
      dealt          <= '0;
      filled         <= '0;
      done           <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == cds_pkg::REG_PASSES)) begin
        shuffle_passes <= pwdata[cds_pkg::PASS_W-1:0];
      end
      done <= (state == cds_pkg::ST_FINISH);
      unique case (state)
        cds_pkg::ST_IDLE: begin
          if (accept) begin
            card_valid <= 1'b0;
            card_value <= '0;
            card_suit  <= '0;
            if (cmd == cds_pkg::FUNC_DEAL) begin
              addr_a <= dealt[AW-1:0];
            end else begin
              addr_a <= top_pos[AW-1:0];
            end
            if (cmd == cds_pkg::FUNC_ORDER) begin
              filled     <= '0;
              swap_pos   <= '0;
              pass_count <= '0;
              dealt      <= '0;
            end else if ((cmd == cds_pkg::FUNC_SHUFFLE) && active && !(swap_pos < left)) begin
              swap_pos   <= '0;
              pass_count <= pass_count + cds_pkg::PASS_W'(1);
            end
          end
        end
        cds_pkg::ST_DIVIDE: begin
          if (mod_done) begin
            addr_b <= AW'(CW'(addr_a) + mod_rem);
          end
        end
        cds_pkg::ST_WRITE_A: begin
          filled[addr_a] <= 1'b1;
        end
        cds_pkg::ST_WRITE_B: begin
          filled[addr_b] <= 1'b1;
          if (swap_inc >= left) begin
            swap_pos   <= '0;
            pass_count <= pass_count + cds_pkg::PASS_W'(1);
          end else begin
            swap_pos <= swap_inc;
          end
        end
        cds_pkg::ST_DEAL: begin
          card_valid <= 1'b1;
          card_value <= cds_pkg::rank_of(card_wide);
          card_suit  <= cds_pkg::SUIT_W'(card_wide[1:0]) + cds_pkg::SUIT_BASE;
          dealt      <= dealt + CW'(1);
        end
        cds_pkg::ST_FINISH: begin
          shuffle_done <= (pass_count >= shuffle_passes);
          cards_left   <= cds_pkg::LEFT_W'(left);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cds_pkg::ST_READ) || (state == cds_pkg::ST_DEAL_READ)) begin
      rd_a  <= mem[addr_a];
      vld_a <= filled[addr_a];
    end
    if (state == cds_pkg::ST_READ) begin
      rd_b  <= mem[addr_b];
      vld_b <= filled[addr_b];
    end
    if (state == cds_pkg::ST_WRITE_A) begin
      mem[addr_a] <= card_b;
    end
    if (state == cds_pkg::ST_WRITE_B) begin
      mem[addr_b] <= card_a;
    end
  end

  `CDS_ASSERT(a_done_after_finish, clk, rst, done |-> $past(state) == cds_pkg::ST_FINISH)
  `CDS_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy)
  `CDS_ASSERT(a_dealt_bound, clk, rst, dealt <= DECK_N)

endmodule

// ===== hdl/cds_serial_mod.sv =====
// Bit-serial restoring modulo of the random word by the remaining span.
`timescale 1ns / 1ps
`include "card_deck_shuffler_defines.svh"
module cds_serial_mod #(
  parameter int DIV_W = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [cds_pkg::RND_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         remainder
);

  logic [cds_pkg::RND_W-1:0]  shreg;
  logic [DIV_W-1:0]           dvsr;
  logic [cds_pkg::STEP_W-1:0] step;
  logic                       running;
  logic [DIV_W:0]             trial;

  assign trial = {remainder, shreg[cds_pkg::RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        shreg     <= dividend;
        dvsr      <= divisor;
        remainder <= '0;
        step      <= '0;
        running   <= 1'b1;
      end else if (running) begin
        shreg <= {shreg[cds_pkg::RND_W-2:0], 1'b0};
        if (trial >= {1'b0, dvsr}) begin
          remainder <= DIV_W'(trial - {1'b0, dvsr});
        end else begin
          remainder <= DIV_W'(trial);
        end
        step <= step + cds_pkg::STEP_W'(1);
        if (step == cds_pkg::STEP_W'(cds_pkg::RND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  `CDS_ASSERT(a_load_when_idle, clk, rst, load |-> !running)
  `CDS_ASSERT(a_divisor_nonzero, clk, rst, load |-> divisor != '0)
  `CDS_ASSERT(a_remainder_range, clk, rst, done |-> remainder < dvsr)

endmodule

// ===== bench/card_deck_shuffler_tb.sv =====
// Self-checking testbench for the card deck shuffler: directed cases, then random phases.
`timescale 1ns / 1ps
module card_deck_shuffler_tb;

  localparam int DECK_N = 52;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP = 20;
  localparam logic [cds_pkg::RND_W-1:0] RND_TOP = 27'd99999999;
  localparam logic [cds_pkg::RND_W-1:0] RND_ALL = {cds_pkg::RND_W{1'b1}};

  typedef struct packed {
    logic                        valid;
    logic [cds_pkg::VALUE_W-1:0] value;
    logic [cds_pkg::SUIT_W-1:0]  suit;
    logic                        shuffled;
    logic [cds_pkg::LEFT_W-1:0]  left;
  } outcome_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [cds_pkg::FUNC_W-1:0]   func;
  logic [cds_pkg::RND_W-1:0]    random_word;
  logic                         done;
  logic                         card_valid;
  logic [cds_pkg::VALUE_W-1:0]  card_value;
  logic [cds_pkg::SUIT_W-1:0]   card_suit;
  logic                         shuffle_done;
  logic [cds_pkg::LEFT_W-1:0]   cards_left;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cds_pkg::PADDR_W-1:0]  paddr;
  logic [cds_pkg::APB_W-1:0]    pwdata;
  logic [cds_pkg::APB_W-1:0]    prdata;
  logic                         pready;

  logic [cds_pkg::CARD_W-1:0]   deck_image [64];
  int unsigned                  walk_pos;
  int unsigned                  passes_run;
  int unsigned                  cards_dealt;
  logic [cds_pkg::PASS_W-1:0]   pass_limit;

  outcome_t            pending_outcomes [$];
  int unsigned         errors;
  int unsigned         results_seen;
  int unsigned         commands_sent;
  int unsigned         shuffle_steps;
  int unsigned         cards_out;
  int unsigned         empty_deals;
  int unsigned         done_results;
  int unsigned         settings_used;
  int unsigned         stall_cycles;
  bit                  steady_flow;

  card_deck_shuffler #(.DECK_SIZE(DECK_N)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .random_word(random_word), .done(done), .card_valid(card_valid),
    .card_value(card_value), .card_suit(card_suit), .shuffle_done(shuffle_done),
    .cards_left(cards_left), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
               got, want);
    end
  endtask

  function automatic void order_image();
    for (int i = 0; i < 64; i++) begin
      deck_image[i] = cds_pkg::CARD_W'(i);
    end
    walk_pos = 0;
    passes_run = 0;
    cards_dealt = 0;
  endfunction

  function automatic void play_command(input cds_pkg::func_t f,
                                       input logic [cds_pkg::RND_W-1:0] rw,
                                       output outcome_t o);
    int unsigned remain;
    int unsigned span;
    int unsigned pick;
    int unsigned pa;
    int unsigned pb;
    logic [cds_pkg::CARD_W-1:0] held;
    o = '0;
    case (f)
      cds_pkg::FUNC_ORDER: begin
        order_image();
      end
      cds_pkg::FUNC_SHUFFLE: begin
        if (passes_run < pass_limit) begin
          remain = DECK_N - cards_dealt;
          if (walk_pos < remain) begin
            span = remain - walk_pos;
            pick = rw % span;
            pa = (cards_dealt + walk_pos) & 63;
            pb = (cards_dealt + walk_pos + pick) & 63;
            held = deck_image[pa];
            deck_image[pa] = deck_image[pb];
            deck_image[pb] = held;
            walk_pos++;
            if (walk_pos >= remain) begin
              walk_pos = 0;
              passes_run++;
            end
          end else begin
            walk_pos = 0;
            passes_run++;
          end
        end
      end
      cds_pkg::FUNC_DEAL: begin
        if (cards_dealt < DECK_N) begin
          held = deck_image[cards_dealt & 63];
          o.valid = 1'b1;
          o.value = cds_pkg::VALUE_W'(held % 13 + 2);
          o.suit = cds_pkg::SUIT_W'(held % 4 + 1);
          cards_dealt++;
        end
      end
      default: begin
      end
    endcase
    o.shuffled = (passes_run >= pass_limit);
    o.left = cds_pkg::LEFT_W'(DECK_N - cards_dealt);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cds_pkg::RND_W-1:0] rnd_word();
    if ($urandom_range(0, 4) == 0) begin
      return cds_pkg::RND_W'($urandom());
    end
    return cds_pkg::RND_W'($urandom_range(0, 99999999));
  endfunction

  task automatic send_command(input cds_pkg::func_t f, input logic [cds_pkg::RND_W-1:0] rw);
    outcome_t o;
    int unsigned gap;
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    random_word <= rw;
    do @(posedge clk); while (busy);
    play_command(f, rw, o);
    pending_outcomes.push_back(o);
    if (f != cds_pkg::FUNC_NOP) begin
      commands_sent++;
    end
    if (f == cds_pkg::FUNC_SHUFFLE) begin
      shuffle_steps++;
    end
    if (f == cds_pkg::FUNC_DEAL) begin
      if (o.valid) begin
        cards_out++;
      end else begin
        empty_deals++;
      end
    end
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic read_passes();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= cds_pkg::PADDR_W'(4 * cds_pkg::REG_PASSES);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != cds_pkg::APB_W'(pass_limit)) begin
      report_mismatch("register readback", prdata, pass_limit);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_passes(input logic [cds_pkg::PASS_W-1:0] setting);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= cds_pkg::PADDR_W'(4 * cds_pkg::REG_PASSES);
    pwdata <= cds_pkg::APB_W'(setting);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pass_limit = setting;
    settings_used++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_passes();
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (shuffle_done) begin
        done_results++;
      end
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (card_valid !== want.valid) report_mismatch("card_valid", card_valid, want.valid);
        if (card_value !== want.value) report_mismatch("card_value", card_value, want.value);
        if (card_suit !== want.suit) report_mismatch("card_suit", card_suit, want.suit);
        if (shuffle_done !== want.shuffled) begin
          report_mismatch("shuffle_done", shuffle_done, want.shuffled);
        end
        if (cards_left !== want.left) report_mismatch("cards_left", cards_left, want.left);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("card_deck_shuffler test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_after_reset();
    read_passes();
    send_command(cds_pkg::FUNC_DEAL, '0);
    send_command(cds_pkg::FUNC_DEAL, RND_ALL);
    send_command(cds_pkg::FUNC_NOP, RND_ALL);
    send_command(cds_pkg::FUNC_ORDER, RND_TOP);
  endtask

  task automatic test_shuffle_extremes();
    write_passes(4'd15);
    send_command(cds_pkg::FUNC_SHUFFLE, '0);
    send_command(cds_pkg::FUNC_SHUFFLE, RND_TOP);
    send_command(cds_pkg::FUNC_SHUFFLE, RND_ALL);
    send_command(cds_pkg::FUNC_SHUFFLE, 27'd1);
    send_command(cds_pkg::FUNC_SHUFFLE, 27'h2AAAAAA);
    send_command(cds_pkg::FUNC_DEAL, '0);
    send_command(cds_pkg::FUNC_DEAL, '0);
    send_command(cds_pkg::FUNC_ORDER, '0);
  endtask

  task automatic test_deal_out();
    write_passes(4'd2);
    send_command(cds_pkg::FUNC_ORDER, '0);
    repeat (DECK_N - 3) send_command(cds_pkg::FUNC_DEAL, rnd_word());
    send_command(cds_pkg::FUNC_SHUFFLE, RND_TOP);
    send_command(cds_pkg::FUNC_SHUFFLE, RND_ALL);
    send_command(cds_pkg::FUNC_DEAL, '0);
    send_command(cds_pkg::FUNC_DEAL, '0);
    // With one card left the walk position is already past the top; the pass closes.
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    send_command(cds_pkg::FUNC_DEAL, '0);
    send_command(cds_pkg::FUNC_DEAL, '0);
    write_passes(4'd3);
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
  endtask

  task automatic test_passes_lowered();
    write_passes(4'd2);
    send_command(cds_pkg::FUNC_NOP, '0);
    write_passes(4'd5);
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    send_command(cds_pkg::FUNC_NOP, rnd_word());
    write_passes(4'd15);
    send_command(cds_pkg::FUNC_ORDER, '0);
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
    write_passes(4'd0);
    send_command(cds_pkg::FUNC_SHUFFLE, RND_TOP);
    send_command(cds_pkg::FUNC_DEAL, '0);
    write_passes(4'd1);
    send_command(cds_pkg::FUNC_SHUFFLE, '0);
  endtask

  task automatic test_random_phases(input int unsigned target);
    int unsigned r;
    int unsigned len;
    logic [cds_pkg::PASS_W-1:0] setting;
    while (commands_sent < target) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        setting = 4'd1;
      end else if (r == 1) begin
        setting = 4'd15;
      end else if (r == 2) begin
        setting = 4'd0;
      end else begin
        setting = cds_pkg::PASS_W'($urandom_range(1, 15));
      end
      write_passes(setting);
      steady_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_command(cds_pkg::FUNC_ORDER, rnd_word());
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(38, DECK_N)) send_command(cds_pkg::FUNC_DEAL, rnd_word());
      end
      len = $urandom_range(20, 100);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_command(cds_pkg::FUNC_SHUFFLE, rnd_word());
        end else if (r < 90) begin
          send_command(cds_pkg::FUNC_DEAL, rnd_word());
        end else if (r < 95) begin
          send_command(cds_pkg::FUNC_ORDER, rnd_word());
        end else begin
          send_command(cds_pkg::FUNC_NOP, rnd_word());
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= cds_pkg::FUNC_ORDER;
    random_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    errors = 0;
    results_seen = 0;
    commands_sent = 0;
    shuffle_steps = 0;
    cards_out = 0;
    empty_deals = 0;
    done_results = 0;
    settings_used = 0;
    steady_flow = 1'b0;
    order_image();
    pass_limit = cds_pkg::PASSES_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_shuffle_extremes();
    test_deal_out();
    test_passes_lowered();
    test_random_phases(1000);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Ran %0d commands: %0d shuffle steps, %0d cards dealt, %0d empty deals.",
             commands_sent, shuffle_steps, cards_out, empty_deals);
    $display("Checked %0d results (%0d with the shuffle done) over %0d register writes.",
             results_seen, done_results, settings_used);
    if (errors == 0) begin
      $display("card_deck_shuffler test passed");
    end else begin
      $display("card_deck_shuffler test failed");
    end
    $finish;
  end

endmodule
